// ----- hdl/rcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

  // Field widths
  localparam int RAW_W   = 11;
  localparam int GAIN_W  = 16;
  localparam int OFF_W   = 16;
  localparam int STICK_W = 12;
  localparam int MODE_W  = 16;
  localparam int FM_W    = 3;
  localparam int CNT_W   = 32;
  localparam int DB_W    = 10;
  localparam int TMO_W   = 16;

  localparam int N_STICK = 4;
  localparam int N_MODE  = 3;

  // Register reset values
  localparam logic [STICK_W-1:0] PWM_MIN_RST = 12'd1000;
  localparam logic [STICK_W-1:0] PWM_MAX_RST = 12'd2000;
  localparam logic [RAW_W-1:0]   ARM_THR_RST = 11'd1000;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd500;

  // Mode switch decode levels
  localparam logic [MODE_W-1:0] MODE_LOW  = 16'd1000;
  localparam logic [MODE_W-1:0] MODE_HIGH = 16'd1512;

  // Flight mode codes
  localparam logic [FM_W-1:0] FM_NONE = 3'd0;
  localparam logic [FM_W-1:0] FM_M1   = 3'd1;
  localparam logic [FM_W-1:0] FM_M2   = 3'd2;
  localparam logic [FM_W-1:0] FM_M3   = 3'd3;
  localparam logic [FM_W-1:0] FM_M4   = 3'd4;
  localparam logic [FM_W-1:0] FM_M5   = 3'd5;

  // Request kinds
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    REG_STICK_GAINS,
    REG_STICK_OFFSETS,
    REG_MODE_GAIN_OFFSET,
    REG_PWM_MIN,
    REG_PWM_MAX,
    REG_DEADBAND,
    REG_ARM_LEVEL,
    REG_SIGNAL_TIMEOUT
  } rcc_reg_t;

  typedef struct packed {
    logic             op;
    logic [RAW_W-1:0] roll_raw;
    logic [RAW_W-1:0] pitch_raw;
    logic [RAW_W-1:0] throttle_raw;
    logic [RAW_W-1:0] yaw_raw;
    logic [RAW_W-1:0] arm_raw;
    logic [RAW_W-1:0] mode_raw;
    logic [RAW_W-1:0] mode_backup_raw;
    logic [RAW_W-1:0] vehicle_mode_raw;
    logic             frame_lost;
    logic             failsafe_flag;
  } rcc_req_t;

  typedef struct packed {
    logic [STICK_W-1:0] roll_out;
    logic [STICK_W-1:0] pitch_out;
    logic [STICK_W-1:0] throttle_out;
    logic [STICK_W-1:0] yaw_out;
    logic [MODE_W-1:0]  mode_value;
    logic [MODE_W-1:0]  mode_backup_value;
    logic [MODE_W-1:0]  vehicle_mode_value;
    logic               armed;
    logic               signal_lost;
    logic [FM_W-1:0]    flight_mode;
    logic [CNT_W-1:0]   item_count;
  } rcc_rsp_t;

  // Commit-stage control from the lane stage
  typedef struct packed {
    logic go;
    logic tick;
    logic bad;
    logic arm_hit;
  } rcc_ctl_t;

  // Static settings used by the merge stage
  typedef struct packed {
    logic [STICK_W-1:0] pwm_min;
    logic [STICK_W-1:0] pwm_max;
    logic [DB_W-1:0]    deadband;
    logic [TMO_W-1:0]   timeout;
  } rcc_cfg_t;

  // Width of a signed scaled value: truncated product plus offset, with room to spare
  function automatic int sum_width(input int frac);
    int pw;
    pw = RAW_W + GAIN_W - frac;
    return ((pw > OFF_W) ? pw : OFF_W) + 2;
  endfunction

  function automatic logic [FM_W-1:0] decode_mode(input logic [MODE_W-1:0] m,
                                                 input logic [MODE_W-1:0] b,
                                                 input logic [FM_W-1:0]   prev);
    logic [FM_W-1:0] code;
    code = prev;
    if (m < MODE_LOW) begin
      if (b <= MODE_LOW) begin
        code = FM_M1;
      end else if (b <= MODE_HIGH) begin
        code = FM_M2;
      end else begin
        code = FM_M3;
      end
    end else if (b >= MODE_HIGH) begin
      if (m > MODE_LOW && m <= MODE_HIGH) begin
        code = FM_M4;
      end else if (m >= MODE_HIGH) begin
        code = FM_M5;
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rc_channel_conditioner_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A request accepted on the channel is registered in the lane multiply stage and then
// committed by the commit stage, whose state also serves as the result register.
// Throughput: one request per cycle while rsp_stall does not hold back a shown result.
// Reset (rst, synchronous, active high) clears all held channel state, flags, counters,
// pipeline valids and loads the register defaults; no clearing pass is needed.
module rc_channel_conditioner_core #(
  parameter int GAIN_FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire rcc_pkg::rcc_req_t req_data,
  // result channel
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rcc_pkg::rcc_rsp_t      rsp_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [5:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  localparam int SW = rcc_pkg::sum_width(GAIN_FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers, one per 8-byte slot
  // ---------------------------------------------------------------------------
  logic [63:0]                  stick_gains;
  logic [63:0]                  stick_offsets;
  logic [31:0]                  mode_gain_offset;
  logic [rcc_pkg::STICK_W-1:0]  pwm_min;
  logic [rcc_pkg::STICK_W-1:0]  pwm_max;
  logic [rcc_pkg::DB_W-1:0]     deadband;
  logic [rcc_pkg::RAW_W-1:0]    arm_level;
  logic [rcc_pkg::TMO_W-1:0]    link_timeout;

  rcc_pkg::rcc_reg_t            reg_sel;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = rcc_pkg::rcc_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_gains      <= '0;
      stick_offsets    <= '0;
      mode_gain_offset <= '0;
      pwm_min          <= rcc_pkg::PWM_MIN_RST;
      pwm_max          <= rcc_pkg::PWM_MAX_RST;
      deadband         <= '0;
      arm_level        <= rcc_pkg::ARM_THR_RST;
      link_timeout     <= rcc_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        rcc_pkg::REG_STICK_GAINS:      stick_gains      <= pwdata;
        rcc_pkg::REG_STICK_OFFSETS:    stick_offsets    <= pwdata;
        rcc_pkg::REG_MODE_GAIN_OFFSET: mode_gain_offset <= pwdata[31:0];
        rcc_pkg::REG_PWM_MIN:          pwm_min          <= pwdata[rcc_pkg::STICK_W-1:0];
        rcc_pkg::REG_PWM_MAX:          pwm_max          <= pwdata[rcc_pkg::STICK_W-1:0];
        rcc_pkg::REG_DEADBAND:         deadband         <= pwdata[rcc_pkg::DB_W-1:0];
        rcc_pkg::REG_ARM_LEVEL:        arm_level        <= pwdata[rcc_pkg::RAW_W-1:0];
        rcc_pkg::REG_SIGNAL_TIMEOUT:   link_timeout     <= pwdata[rcc_pkg::TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rcc_pkg::REG_STICK_GAINS:      prdata = stick_gains;
      rcc_pkg::REG_STICK_OFFSETS:    prdata = stick_offsets;
      rcc_pkg::REG_MODE_GAIN_OFFSET: prdata = 64'(mode_gain_offset);
      rcc_pkg::REG_PWM_MIN:          prdata = 64'(pwm_min);
      rcc_pkg::REG_PWM_MAX:          prdata = 64'(pwm_max);
      rcc_pkg::REG_DEADBAND:         prdata = 64'(deadband);
      rcc_pkg::REG_ARM_LEVEL:        prdata = 64'(arm_level);
      rcc_pkg::REG_SIGNAL_TIMEOUT:   prdata = 64'(link_timeout);
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  //   stage 1: lane products registered, request flags captured
  //   stage 2: merge commits state, which is what rsp_data shows
  // The commit stalls only while a shown result is held off by rsp_stall;
  // stage 1 still fills behind it.
  // ---------------------------------------------------------------------------
  logic              s1_valid;
  logic              s1_tick;
  logic              s1_bad;
  logic              s1_arm_hit;
  logic              load;
  logic              commit;
  rcc_pkg::rcc_ctl_t ctl;
  rcc_pkg::rcc_cfg_t mcfg;

  assign commit    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !commit;
  assign load      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // only bit 0 of op matters; arm compare done early: user keeps threshold static while busy, block does not enforce
  always_ff @(posedge clk) begin
    if (load) begin
      s1_tick    <= (req_data.op == rcc_pkg::OP_TICK);
      s1_bad     <= req_data.frame_lost || req_data.failsafe_flag;
      s1_arm_hit <= req_data.arm_raw > arm_level;
    end
  end

  always_comb begin
    ctl.go      = commit;
    ctl.tick    = s1_tick;
    ctl.bad     = s1_bad;
    ctl.arm_hit = s1_arm_hit;
    mcfg.pwm_min  = pwm_min;
    mcfg.pwm_max  = pwm_max;
    mcfg.deadband = deadband;
    mcfg.timeout  = link_timeout;
  end

  // ---------------------------------------------------------------------------
  // Scaling lanes: four sticks with their own gain/offset, three mode
  // channels sharing one gain/offset
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::RAW_W-1:0] stick_raw [rcc_pkg::N_STICK];
  logic [rcc_pkg::RAW_W-1:0] mode_raw  [rcc_pkg::N_MODE];
  logic signed [SW-1:0]      stick_v   [rcc_pkg::N_STICK];
  logic signed [SW-1:0]      mode_v    [rcc_pkg::N_MODE];

  always_comb begin
    stick_raw[0] = req_data.roll_raw;
    stick_raw[1] = req_data.pitch_raw;
    stick_raw[2] = req_data.throttle_raw;
    stick_raw[3] = req_data.yaw_raw;
    mode_raw[0]  = req_data.mode_raw;
    mode_raw[1]  = req_data.mode_backup_raw;
    mode_raw[2]  = req_data.vehicle_mode_raw;
  end

  for (genvar i = 0; i < rcc_pkg::N_STICK; i++) begin : g_stick
    rcc_scale_lane #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (load),
      .raw    (stick_raw[i]),
      .gain   (stick_gains[rcc_pkg::GAIN_W*i +: rcc_pkg::GAIN_W]),
      .offset ($signed(stick_offsets[rcc_pkg::OFF_W*i +: rcc_pkg::OFF_W])),
      .value  (stick_v[i])
    );
  end

  for (genvar i = 0; i < rcc_pkg::N_MODE; i++) begin : g_mode
    rcc_scale_lane #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (load),
      .raw    (mode_raw[i]),
      .gain   (mode_gain_offset[rcc_pkg::GAIN_W-1:0]),
      .offset ($signed(mode_gain_offset[31:rcc_pkg::GAIN_W])),
      .value  (mode_v[i])
    );
  end

  rcc_merge #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .cfg     (mcfg),
    .stick_v (stick_v),
    .mode_v  (mode_v),
    .rsp     (rsp_data)
  );

  // back-pressure toward the sender only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled without a blocked result");

endmodule

`default_nettype wire

// ----- hdl/rcc_scale_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One channel: registered raw * gain >> frac, then signed offset added.
module rcc_scale_lane #(
  parameter int GAIN_FRAC_BITS = 14
) (
  input  wire logic                                             clk,
  input  wire logic                                             en,
  input  wire logic [rcc_pkg::RAW_W-1:0]                        raw,
  input  wire logic [rcc_pkg::GAIN_W-1:0]                       gain,
  input  wire logic signed [rcc_pkg::OFF_W-1:0]                 offset,
  output logic signed [rcc_pkg::sum_width(GAIN_FRAC_BITS)-1:0]  value
);

  localparam int FULL_W = rcc_pkg::RAW_W + rcc_pkg::GAIN_W;
  localparam int PW     = FULL_W - GAIN_FRAC_BITS;
  localparam int SW     = rcc_pkg::sum_width(GAIN_FRAC_BITS);

  logic [FULL_W-1:0] full;
  logic [PW-1:0]     prod;

  assign full = {{rcc_pkg::GAIN_W{1'b0}}, raw} * {{rcc_pkg::RAW_W{1'b0}}, gain};

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[FULL_W-1:GAIN_FRAC_BITS];
    end
  end

  assign value = $signed(SW'(prod)) + SW'(offset);

endmodule

`default_nettype wire

// ----- hdl/rcc_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Commit stage: clamp/deadband per stick, mode saturation and decode,
// link-loss tracking and item counter. State doubles as the result register.
module rcc_merge #(
  parameter int GAIN_FRAC_BITS = 14
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst,
  input  wire rcc_pkg::rcc_ctl_t                                   ctl,
  input  wire rcc_pkg::rcc_cfg_t                                   cfg,
  input  wire logic signed [rcc_pkg::sum_width(GAIN_FRAC_BITS)-1:0] stick_v [rcc_pkg::N_STICK],
  input  wire logic signed [rcc_pkg::sum_width(GAIN_FRAC_BITS)-1:0] mode_v  [rcc_pkg::N_MODE],
  output rcc_pkg::rcc_rsp_t                                        rsp
);

  localparam int SW = rcc_pkg::sum_width(GAIN_FRAC_BITS);

  logic [rcc_pkg::STICK_W-1:0] held      [rcc_pkg::N_STICK];
  logic [rcc_pkg::STICK_W-1:0] held_next [rcc_pkg::N_STICK];
  logic [rcc_pkg::MODE_W-1:0]  mode_scaled      [rcc_pkg::N_MODE];
  logic [rcc_pkg::MODE_W-1:0]  mode_scaled_next [rcc_pkg::N_MODE];
  logic                        armed_flag, armed_flag_next;
  logic                        lost_flag, lost_flag_next;
  logic [rcc_pkg::FM_W-1:0]    mode_code, mode_code_next;
  logic [rcc_pkg::CNT_W-1:0]   ms_since_good, ms_since_good_next;
  logic [rcc_pkg::CNT_W-1:0]   items_seen;

  logic                        good;
  logic [rcc_pkg::STICK_W-1:0] clamped [rcc_pkg::N_STICK];
  logic [rcc_pkg::STICK_W-1:0] delta   [rcc_pkg::N_STICK];
  logic [rcc_pkg::MODE_W-1:0]  sat     [rcc_pkg::N_MODE];

  assign good = !ctl.tick && !ctl.bad;

  always_comb begin
    for (int i = 0; i < rcc_pkg::N_STICK; i++) begin
      if (stick_v[i] < $signed(SW'(cfg.pwm_min))) begin
        clamped[i] = cfg.pwm_min;
      end else if (stick_v[i] > $signed(SW'(cfg.pwm_max))) begin
        clamped[i] = cfg.pwm_max;
      end else begin
        clamped[i] = stick_v[i][rcc_pkg::STICK_W-1:0];
      end
      delta[i] = (clamped[i] > held[i]) ? (clamped[i] - held[i]) : (held[i] - clamped[i]);
      held_next[i] = (good && delta[i] > rcc_pkg::STICK_W'(cfg.deadband)) ? clamped[i]
                                                                          : held[i];
    end
    for (int i = 0; i < rcc_pkg::N_MODE; i++) begin
      if (mode_v[i][SW-1]) begin
        sat[i] = '0;
      end else if (mode_v[i] > $signed(SW'({rcc_pkg::MODE_W{1'b1}}))) begin
        sat[i] = '1;
      end else begin
        sat[i] = mode_v[i][rcc_pkg::MODE_W-1:0];
      end
      mode_scaled_next[i] = good ? sat[i] : mode_scaled[i];
    end
    armed_flag_next = good ? ctl.arm_hit : armed_flag;
    mode_code_next  = good ? rcc_pkg::decode_mode(sat[0], sat[1], mode_code) : mode_code;

    // time only moves on ticks; a good frame restarts it
    if (ctl.tick) begin
      ms_since_good_next = (ms_since_good == '1) ? ms_since_good : ms_since_good + 1'b1;
    end else if (ctl.bad) begin
      ms_since_good_next = ms_since_good;
    end else begin
      ms_since_good_next = '0;
    end

    if (ctl.tick) begin
      lost_flag_next = lost_flag ||
                       (ms_since_good_next > rcc_pkg::CNT_W'(cfg.timeout));
    end else begin
      lost_flag_next = ctl.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rcc_pkg::N_STICK; i++) begin
        held[i] <= '0;
      end
      for (int i = 0; i < rcc_pkg::N_MODE; i++) begin
        mode_scaled[i] <= '0;
      end
      armed_flag    <= 1'b0;
      lost_flag     <= 1'b0;
      mode_code     <= rcc_pkg::FM_NONE;
      ms_since_good <= '0;
      items_seen    <= '0;
    end else if (ctl.go) begin
      held          <= held_next;
      mode_scaled   <= mode_scaled_next;
      armed_flag    <= armed_flag_next;
      lost_flag     <= lost_flag_next;
      mode_code     <= mode_code_next;
      ms_since_good <= ms_since_good_next;
      items_seen    <= items_seen + 1'b1;
    end
  end

  always_comb begin
    rsp.roll_out           = held[0];
    rsp.pitch_out          = held[1];
    rsp.throttle_out       = held[2];
    rsp.yaw_out            = held[3];
    rsp.mode_value         = mode_scaled[0];
    rsp.mode_backup_value  = mode_scaled[1];
    rsp.vehicle_mode_value = mode_scaled[2];
    rsp.armed              = armed_flag;
    rsp.signal_lost        = lost_flag;
    rsp.flight_mode        = mode_code;
    rsp.item_count         = items_seen;
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ctl.go |=> items_seen == $past(items_seen) + 32'd1)
    else $error("item counter did not step on commit");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode_code <= rcc_pkg::FM_M5)
    else $error("flight mode code out of range");

  a_good_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.go && !ctl.tick && !ctl.bad |=> !lost_flag && ms_since_good == '0)
    else $error("good frame did not clear link loss");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !ctl.go |=> $stable(items_seen) && $stable(lost_flag) && $stable(mode_code))
    else $error("state moved without a commit");

endmodule

`default_nettype wire

// ----- verif/tb_rc_channel_conditioner_core.sv -----
`timescale 1ns / 1ps

module tb_rc_channel_conditioner_core;

  localparam int FRAC        = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 400;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 130;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic              req_valid = 1'b0;
  logic              req_stall;
  rcc_pkg::rcc_req_t req_data  = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rcc_pkg::rcc_rsp_t rsp_data;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [5:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic [63:0] prdata;
  logic        pready;

  rc_channel_conditioner_core #(
    .GAIN_FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file, updated as each APB write lands
  // ---------------------------------------------------------------------------
  logic [63:0]                 cfg_gains    = '0;
  logic [63:0]                 cfg_offs     = '0;
  logic [31:0]                 cfg_mode_go  = '0;
  logic [rcc_pkg::STICK_W-1:0] cfg_pwm_min  = rcc_pkg::PWM_MIN_RST;
  logic [rcc_pkg::STICK_W-1:0] cfg_pwm_max  = rcc_pkg::PWM_MAX_RST;
  logic [rcc_pkg::DB_W-1:0]    cfg_deadband = '0;
  logic [rcc_pkg::RAW_W-1:0]   cfg_arm_thr  = rcc_pkg::ARM_THR_RST;
  logic [rcc_pkg::TMO_W-1:0]   cfg_timeout  = rcc_pkg::TIMEOUT_RST;

  // Conditioner state as the predictor sees it
  logic [rcc_pkg::STICK_W-1:0] held_sticks [rcc_pkg::N_STICK] = '{default: '0};
  logic [rcc_pkg::MODE_W-1:0]  held_modes  [rcc_pkg::N_MODE]  = '{default: '0};
  logic                        armed_q    = 1'b0;
  logic                        lost_q     = 1'b0;
  logic [rcc_pkg::FM_W-1:0]    fmode_q    = rcc_pkg::FM_NONE;
  logic [31:0]                 ms_count   = '0;
  logic [rcc_pkg::CNT_W-1:0]   item_total = '0;

  // Stimulus / scoreboard plumbing
  rcc_pkg::rcc_req_t pending_reqs[$];
  rcc_pkg::rcc_rsp_t expected_rsps[$];
  rcc_pkg::rcc_rsp_t rsp_want;

  int  accepted_total  = 0;
  int  results_seen    = 0;
  int  mismatch_total  = 0;
  int  frames_sent     = 0;
  int  bad_frames_sent = 0;
  int  ticks_sent      = 0;
  int  settings_count  = 0;
  int  cycle_count     = 0;
  int  gap_left        = 0;
  int  stall_left      = 0;
  int  hold_cycles     = 0;
  bit  sender_gaps     = 1'b0;
  bit  receiver_stalls = 1'b0;
  bit  hold_phase      = 1'b0;
  int  stick_base [rcc_pkg::N_STICK] = '{1500, 1500, 1500, 1500};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // raw * Q2.14 gain, truncated, plus a signed 16-bit offset; no wrap anywhere
  function automatic longint scale_q(logic [rcc_pkg::RAW_W-1:0] raw,
                                     logic [rcc_pkg::GAIN_W-1:0] gain,
                                     logic [rcc_pkg::OFF_W-1:0] off);
    longint prod;
    prod = (longint'(raw) * longint'(gain)) >> FRAC;
    return prod + longint'($signed(off));
  endfunction

  function automatic rcc_pkg::rcc_rsp_t predict_conditioned(rcc_pkg::rcc_req_t r);
    rcc_pkg::rcc_rsp_t         o;
    logic [rcc_pkg::RAW_W-1:0] sraw [rcc_pkg::N_STICK];
    logic [rcc_pkg::RAW_W-1:0] mraw [rcc_pkg::N_MODE];
    longint                    v;
    longint                    d;
    sraw = '{r.roll_raw, r.pitch_raw, r.throttle_raw, r.yaw_raw};
    mraw = '{r.mode_raw, r.mode_backup_raw, r.vehicle_mode_raw};
    if (r.op == rcc_pkg::OP_FRAME) begin
      if (r.frame_lost || r.failsafe_flag) begin
        lost_q = 1'b1;
      end else begin
        lost_q   = 1'b0;
        ms_count = '0;
        for (int i = 0; i < rcc_pkg::N_STICK; i++) begin
          v = scale_q(sraw[i], cfg_gains[16*i +: 16], cfg_offs[16*i +: 16]);
          // min wins over max when the limits are crossed
          if (v < longint'(cfg_pwm_min)) begin
            v = longint'(cfg_pwm_min);
          end else if (v > longint'(cfg_pwm_max)) begin
            v = longint'(cfg_pwm_max);
          end
          d = v - longint'(held_sticks[i]);
          if (d < 0) begin
            d = -d;
          end
          if (d > longint'(cfg_deadband)) begin
            held_sticks[i] = v[rcc_pkg::STICK_W-1:0];
          end
        end
        armed_q = (r.arm_raw > cfg_arm_thr);
        for (int i = 0; i < rcc_pkg::N_MODE; i++) begin
          v = scale_q(mraw[i], cfg_mode_go[15:0], cfg_mode_go[31:16]);
          if (v < 0) begin
            v = 0;
          end else if (v > 65535) begin
            v = 65535;
          end
          held_modes[i] = v[rcc_pkg::MODE_W-1:0];
        end
        // flight mode from primary (m) and backup (b); no match keeps the old code
        if (held_modes[0] < rcc_pkg::MODE_LOW) begin
          fmode_q = (held_modes[1] <= rcc_pkg::MODE_LOW)  ? rcc_pkg::FM_M1 :
                    (held_modes[1] <= rcc_pkg::MODE_HIGH) ? rcc_pkg::FM_M2 : rcc_pkg::FM_M3;
        end else if (held_modes[1] >= rcc_pkg::MODE_HIGH &&
                     held_modes[0] > rcc_pkg::MODE_LOW) begin
          fmode_q = (held_modes[0] <= rcc_pkg::MODE_HIGH) ? rcc_pkg::FM_M4 : rcc_pkg::FM_M5;
        end
      end
    end else if (ms_count != 32'hFFFF_FFFF) begin
      ms_count = ms_count + 1;
    end
    if (ms_count > 32'(cfg_timeout)) begin
      lost_q = 1'b1;
    end
    item_total = item_total + 1;

    o.roll_out           = held_sticks[0];
    o.pitch_out          = held_sticks[1];
    o.throttle_out       = held_sticks[2];
    o.yaw_out            = held_sticks[3];
    o.mode_value         = held_modes[0];
    o.mode_backup_value  = held_modes[1];
    o.vehicle_mode_value = held_modes[2];
    o.armed              = armed_q;
    o.signal_lost        = lost_q;
    o.flight_mode        = fmode_q;
    o.item_count         = item_total;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [rcc_pkg::RAW_W-1:0] clip11(int x);
    if (x < 0) begin
      return '0;
    end else if (x > 2047) begin
      return '1;
    end
    return rcc_pkg::RAW_W'(x);
  endfunction

  // four 16-bit lanes, each drawn from [lo, hi] and shifted down by bias
  function automatic logic [63:0] rand_pack4(int lo, int hi, int bias);
    logic [63:0] p;
    for (int i = 0; i < 4; i++) begin
      p[16*i +: 16] = 16'(int'($urandom_range(lo, hi)) - bias);
    end
    return p;
  endfunction

  // mode switch positions cluster around the decode levels
  function automatic logic [rcc_pkg::RAW_W-1:0] mode_pos();
    case ($urandom_range(0, 3))
      0: return clip11(int'($urandom_range(940, 1060)));
      1: return clip11(int'($urandom_range(1450, 1570)));
      2: return clip11(int'($urandom_range(0, 900)));
      default: return rcc_pkg::RAW_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic rcc_pkg::rcc_req_t tick_req();
    rcc_pkg::rcc_req_t r;
    logic [95:0]       noise;
    noise = {$urandom, $urandom, $urandom};
    r     = noise[$bits(rcc_pkg::rcc_req_t)-1:0];
    r.op  = rcc_pkg::OP_TICK;
    return r;
  endfunction

  function automatic rcc_pkg::rcc_req_t frame_req(logic [rcc_pkg::RAW_W-1:0] st,
                                                  logic [rcc_pkg::RAW_W-1:0] arm,
                                                  logic [rcc_pkg::RAW_W-1:0] m,
                                                  logic [rcc_pkg::RAW_W-1:0] b,
                                                  logic lost, logic fs);
    rcc_pkg::rcc_req_t r;
    r.op               = rcc_pkg::OP_FRAME;
    r.roll_raw         = st;
    r.pitch_raw        = ~st;
    r.throttle_raw     = st;
    r.yaw_raw          = st ^ 11'h2AA;
    r.arm_raw          = arm;
    r.mode_raw         = m;
    r.mode_backup_raw  = b;
    r.vehicle_mode_raw = b ^ 11'h555;
    r.frame_lost       = lost;
    r.failsafe_flag    = fs;
    return r;
  endfunction

  // half the time sticks jitter around a slowly moving position so the deadband matters
  function automatic rcc_pkg::rcc_req_t rand_frame();
    rcc_pkg::rcc_req_t         r;
    logic [rcc_pkg::RAW_W-1:0] s [rcc_pkg::N_STICK];
    for (int i = 0; i < rcc_pkg::N_STICK; i++) begin
      if ($urandom_range(0, 1)) begin
        s[i] = clip11(stick_base[i] + int'($urandom_range(0, 120)) - 60);
      end else begin
        s[i] = rcc_pkg::RAW_W'($urandom_range(0, 2047));
      end
      stick_base[i] = int'(s[i]);
    end
    r.op               = rcc_pkg::OP_FRAME;
    r.roll_raw         = s[0];
    r.pitch_raw        = s[1];
    r.throttle_raw     = s[2];
    r.yaw_raw          = s[3];
    r.arm_raw          = rcc_pkg::RAW_W'($urandom_range(0, 2047));
    r.mode_raw         = mode_pos();
    r.mode_backup_raw  = mode_pos();
    r.vehicle_mode_raw = rcc_pkg::RAW_W'($urandom_range(0, 2047));
    r.frame_lost       = ($urandom_range(0, 7) == 0);
    r.failsafe_flag    = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes (setup cycle, then access cycle)
  // ---------------------------------------------------------------------------
  task automatic write_reg(rcc_pkg::rcc_reg_t r, logic [63:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      rcc_pkg::REG_STICK_GAINS:      cfg_gains    = v;
      rcc_pkg::REG_STICK_OFFSETS:    cfg_offs     = v;
      rcc_pkg::REG_MODE_GAIN_OFFSET: cfg_mode_go  = v[31:0];
      rcc_pkg::REG_PWM_MIN:          cfg_pwm_min  = v[rcc_pkg::STICK_W-1:0];
      rcc_pkg::REG_PWM_MAX:          cfg_pwm_max  = v[rcc_pkg::STICK_W-1:0];
      rcc_pkg::REG_DEADBAND:         cfg_deadband = v[rcc_pkg::DB_W-1:0];
      rcc_pkg::REG_ARM_LEVEL:        cfg_arm_thr  = v[rcc_pkg::RAW_W-1:0];
      rcc_pkg::REG_SIGNAL_TIMEOUT:   cfg_timeout  = v[rcc_pkg::TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(logic [63:0] gains, logic [63:0] offs, logic [31:0] mgo,
                                  logic [11:0] pmin, logic [11:0] pmax, logic [9:0] db,
                                  logic [10:0] thr, logic [15:0] tmo);
    write_reg(rcc_pkg::REG_STICK_GAINS, gains);
    write_reg(rcc_pkg::REG_STICK_OFFSETS, offs);
    write_reg(rcc_pkg::REG_MODE_GAIN_OFFSET, {32'd0, mgo});
    write_reg(rcc_pkg::REG_PWM_MIN, {52'd0, pmin});
    write_reg(rcc_pkg::REG_PWM_MAX, {52'd0, pmax});
    write_reg(rcc_pkg::REG_DEADBAND, {54'd0, db});
    write_reg(rcc_pkg::REG_ARM_LEVEL, {53'd0, thr});
    write_reg(rcc_pkg::REG_SIGNAL_TIMEOUT, {48'd0, tmo});
    settings_count++;
    @(negedge clk);
  endtask

  // Everything sent has come back and nothing is queued or on the wire.
  // Checked at the falling edge, clear of the rising-edge updates.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || req_valid || results_seen != accepted_total);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: feeds the queue onto the channel, holds the payload while
  // stalled, inserts random gaps between requests when enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_conditioned(req_data));
        accepted_total++;
        if (req_data.op == rcc_pkg::OP_TICK) begin
          ticks_sent++;
        end else begin
          frames_sent++;
          if (req_data.frame_lost || req_data.failsafe_flag) begin
            bad_frames_sent++;
          end
        end
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_data  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          gap_left = sender_gaps ? pick_gap() : 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver stall: one long hold-off when asked for (the block must
  // back up and stall its request side), otherwise random stalls if enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!hold_phase) begin
      hold_cycles = 0;
    end
    if (hold_phase && hold_cycles < HOLD_LEN) begin
      hold_cycles++;
      rsp_stall <= 1'b1;
    end else begin
      if (stall_left == 0 && receiver_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      if (mismatch_total <= 10) begin
        $display("result %0d: %s expected %0d, got %0d", results_seen, fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= 10) begin
          $display("result %0d arrived with no request outstanding", results_seen);
        end
      end else begin
        rsp_want = expected_rsps.pop_front();
        check_field("roll_out", 32'(rsp_want.roll_out), 32'(rsp_data.roll_out));
        check_field("pitch_out", 32'(rsp_want.pitch_out), 32'(rsp_data.pitch_out));
        check_field("throttle_out", 32'(rsp_want.throttle_out),
                    32'(rsp_data.throttle_out));
        check_field("yaw_out", 32'(rsp_want.yaw_out), 32'(rsp_data.yaw_out));
        check_field("mode_value", 32'(rsp_want.mode_value), 32'(rsp_data.mode_value));
        check_field("mode_backup_value", 32'(rsp_want.mode_backup_value),
                    32'(rsp_data.mode_backup_value));
        check_field("vehicle_mode_value", 32'(rsp_want.vehicle_mode_value),
                    32'(rsp_data.vehicle_mode_value));
        check_field("armed", 32'(rsp_want.armed), 32'(rsp_data.armed));
        check_field("signal_lost", 32'(rsp_want.signal_lost), 32'(rsp_data.signal_lost));
        check_field("flight_mode", 32'(rsp_want.flight_mode), 32'(rsp_data.flight_mode));
        check_field("item_count", rsp_want.item_count, rsp_data.item_count);
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d of %0d results back",
               cycle_count, results_seen, accepted_total);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Unity gains, zero offsets: scaled value equals the raw value, so the clamp,
    // arm threshold and mode decode boundaries can be hit exactly.
    program_settings({4{16'd16384}}, 64'd0, {16'd0, 16'd16384},
                     12'd1000, 12'd2000, 10'd0, 11'd1000, 16'd5);
    pending_reqs.push_back(frame_req(11'd0, 11'd0, 11'd0, 11'd0, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0, 1'b0));
    // arm exactly at threshold, then one above
    pending_reqs.push_back(frame_req(11'd1500, 11'd1000, 11'd500, 11'd1000, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd1501, 11'd1001, 11'd999, 11'd1001, 1'b0, 1'b0));
    // primary low: backup decides between modes 1..3
    pending_reqs.push_back(frame_req(11'd1200, 11'd0, 11'd500, 11'd1512, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd1200, 11'd0, 11'd500, 11'd1513, 1'b0, 1'b0));
    // primary exactly at the low level: no match, mode held
    pending_reqs.push_back(frame_req(11'd1800, 11'd0, 11'd1000, 11'd1600, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd1800, 11'd0, 11'd1001, 11'd1512, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd1000, 11'd0, 11'd1512, 11'd2000, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd999, 11'd0, 11'd1513, 11'd1512, 1'b0, 1'b0));
    // backup below the high level with primary high: mode held
    pending_reqs.push_back(frame_req(11'd2001, 11'd0, 11'd1600, 11'd1511, 1'b0, 1'b0));
    // bad frames change nothing but the lost flag and the item count
    pending_reqs.push_back(frame_req(11'd300, 11'd2000, 11'd200, 11'd200, 1'b1, 1'b0));
    pending_reqs.push_back(frame_req(11'd300, 11'd2000, 11'd200, 11'd200, 1'b0, 1'b1));
    pending_reqs.push_back(frame_req(11'd300, 11'd2000, 11'd200, 11'd200, 1'b1, 1'b1));
    pending_reqs.push_back(frame_req(11'd1234, 11'd1500, 11'd1300, 11'd1700, 1'b0, 1'b0));
    // six ticks against a timeout of five: the sixth sets signal lost
    repeat (6) pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(11'd1234, 11'd1500, 11'd1300, 11'd1700, 1'b0, 1'b0));
    wait_idle();

    // Extremes: full-scale gains, offsets at both ends, open clamp, widest
    // deadband, highest threshold, zero timeout
    program_settings(64'hFFFF_FFFF_FFFF_FFFF, {16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF},
                     {16'h8000, 16'hFFFF}, 12'd0, 12'd4095, 10'd1023, 11'd2047, 16'd0);
    pending_reqs.push_back(frame_req(11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0, 1'b0));
    pending_reqs.push_back(frame_req(11'd0, 11'd0, 11'd0, 11'd0, 1'b0, 1'b0));
    pending_reqs.push_back(tick_req());
    wait_idle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0, 2: begin
          program_settings(rand_pack4(12000, 20000, 0), rand_pack4(0, 600, 300),
                           {16'(int'($urandom_range(0, 400)) - 200),
                            16'($urandom_range(14500, 18000))},
                           12'($urandom_range(800, 1100)), 12'($urandom_range(1900, 2200)),
                           10'($urandom_range(0, 40)), 11'($urandom_range(900, 1100)),
                           16'($urandom_range(0, 30)));
        end
        3: begin
          // crossed limits: low values go to pwm_min, everything else to pwm_max
          program_settings(rand_pack4(8000, 24000, 0), rand_pack4(0, 2000, 1000),
                           {16'd0, 16'd16384}, 12'd3000, 12'd500, 10'd0, 11'd0, 16'd65535);
        end
        4: begin
          program_settings(rand_pack4(12000, 20000, 0), rand_pack4(0, 600, 300),
                           {16'(int'($urandom_range(0, 400)) - 200),
                            16'($urandom_range(14500, 18000))},
                           12'd0, 12'd4095, 10'($urandom_range(200, 1023)),
                           11'($urandom_range(0, 2047)), 16'($urandom_range(0, 10)));
        end
        default: begin
          program_settings({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                           12'($urandom), 12'($urandom), 10'($urandom), 11'($urandom),
                           16'($urandom_range(0, 40)));
        end
      endcase
      sender_gaps     = (ph == 0 || ph == 3 || ph == 4);
      receiver_stalls = (ph == 0 || ph == 3 || ph == 5);
      hold_phase      = (ph == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) begin
          // a run of ticks long enough to trip short timeouts
          burst = $urandom_range(3, 30);
          repeat (burst) pending_reqs.push_back(tick_req());
          n += burst;
        end else begin
          pending_reqs.push_back(($urandom_range(0, 4) == 0) ? tick_req() : rand_frame());
          n++;
        end
      end
      wait_idle();
      hold_phase = 1'b0;
    end

    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (20) @(posedge clk);

    $display("Covered %0d frames (%0d bad) and %0d ticks under %0d register settings,",
             frames_sent, bad_frames_sent, ticks_sent, settings_count);
    $display("including a %0d-cycle result hold-off; %0d results checked, %0d mismatches.",
             HOLD_LEN, results_seen, mismatch_total);
    if (mismatch_total == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
